FILE: rtl/core/afc_pkg.sv
package afc_pkg;

    localparam int DEF_MAX_PLANES  = 6;
    localparam int DEF_COORD_WIDTH = 16;

    // packed plane layout: a 15:0, b 31:16, c 47:32, d 63:48
    localparam int PLANE_W   = 64;
    localparam int COEF_W    = 16;
    localparam int D_LSB     = 48;
    localparam int D_SHIFT   = 14;
    localparam int AXES      = 3;

    // configuration port
    localparam int CFG_IDX_W       = 3;
    localparam int COUNT_W         = 3;
    localparam int PLANE_REGS      = 6;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_ZERO  = 3'd1;

    // containment codes
    localparam logic [1:0] CONT_INSIDE    = 2'd0;
    localparam logic [1:0] CONT_INTERSECT = 2'd1;
    localparam logic [1:0] CONT_OUTSIDE   = 2'd2;

    typedef struct packed {
        logic       valid;
        logic [1:0] res;
    } afc_ctl_t;

endpackage

FILE: rtl/core/afc_cell.sv
module afc_cell #(
    parameter int COORD_WIDTH = afc_pkg::DEF_COORD_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [afc_pkg::PLANE_W-1:0]          plane,
    input  logic                                 enable,
    input  afc_pkg::afc_ctl_t                    ctl_in,
    input  logic [afc_pkg::AXES-1:0][COORD_WIDTH-1:0] lo_in,
    input  logic [afc_pkg::AXES-1:0][COORD_WIDTH-1:0] hi_in,
    output afc_pkg::afc_ctl_t                    ctl_out,
    output logic [afc_pkg::AXES-1:0][COORD_WIDTH-1:0] lo_out,
    output logic [afc_pkg::AXES-1:0][COORD_WIDTH-1:0] hi_out
);
    import afc_pkg::*;

    localparam int PROD_W = COORD_WIDTH + COEF_W;
    localparam int DTERM_W = COEF_W + D_SHIFT;
    localparam int TERM_W = (PROD_W > DTERM_W) ? PROD_W : DTERM_W;
    localparam int SUM_W  = TERM_W + 2;

    // stage 1: per-axis extreme products
    afc_ctl_t                         s1_ctl_reg, s1_ctl_next;
    logic [AXES-1:0][COORD_WIDTH-1:0] s1_lo_reg, s1_hi_reg;
    logic signed [PROD_W-1:0]         s1_pmax_reg  [AXES];
    logic signed [PROD_W-1:0]         s1_pmin_reg  [AXES];
    logic signed [PROD_W-1:0]         s1_pmax_next [AXES];
    logic signed [PROD_W-1:0]         s1_pmin_next [AXES];
    logic signed [COEF_W-1:0]         s1_d_reg;

    // stage 2: sums and verdict
    afc_ctl_t                         ctl_reg, ctl_next;
    logic [AXES-1:0][COORD_WIDTH-1:0] lo_reg, hi_reg;
    logic signed [SUM_W-1:0]          smax, smin;
    logic                             front, behind;
    logic [1:0]                       verdict;

    always_comb
    begin
        logic signed [COEF_W-1:0]      coef;
        logic signed [COORD_WIDTH-1:0] lo_c, hi_c;
        s1_ctl_next = ctl_in;
        for (int j = 0; j < AXES; j++)
        begin
            coef = $signed(plane[j*COEF_W +: COEF_W]);
            lo_c = $signed(lo_in[j]);
            hi_c = $signed(hi_in[j]);
            // a negative coefficient reaches its maximum at the low coordinate
            if (coef[COEF_W-1])
            begin
                s1_pmax_next[j] = coef * lo_c;
                s1_pmin_next[j] = coef * hi_c;
            end
            else
            begin
                s1_pmax_next[j] = coef * hi_c;
                s1_pmin_next[j] = coef * lo_c;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            ctl_reg    <= '0;
        end
        else
        begin
            s1_ctl_reg <= s1_ctl_next;
            ctl_reg    <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_lo_reg <= lo_in;
        s1_hi_reg <= hi_in;
        s1_d_reg  <= $signed(plane[D_LSB +: COEF_W]);
        for (int j = 0; j < AXES; j++)
        begin
            s1_pmax_reg[j] <= s1_pmax_next[j];
            s1_pmin_reg[j] <= s1_pmin_next[j];
        end
        lo_reg <= s1_lo_reg;
        hi_reg <= s1_hi_reg;
    end

    always_comb
    begin
        logic signed [SUM_W-1:0] dterm;
        dterm = SUM_W'(s1_d_reg) <<< D_SHIFT;
        smax  = SUM_W'(s1_pmax_reg[0]) + SUM_W'(s1_pmax_reg[1])
              + SUM_W'(s1_pmax_reg[2]) + dterm;
        smin  = SUM_W'(s1_pmin_reg[0]) + SUM_W'(s1_pmin_reg[1])
              + SUM_W'(s1_pmin_reg[2]) + dterm;
        front  = !smax[SUM_W-1] && (smax != '0);
        behind = smin[SUM_W-1];
        if (!front)
            verdict = CONT_OUTSIDE;
        else if (!behind)
            verdict = CONT_INSIDE;
        else
            verdict = CONT_INTERSECT;

        ctl_next = s1_ctl_reg;
        // keep the first verdict that is not inside
        if (enable && (s1_ctl_reg.res == CONT_INSIDE))
            ctl_next.res = verdict;
    end

    assign ctl_out = ctl_reg;
    assign lo_out  = lo_reg;
    assign hi_out  = hi_reg;

endmodule

FILE: rtl/core/aabb_frustum_classify_unit.sv
// Box-versus-frustum classifier.
// Input: pulse start with the six box coordinates; a transaction is taken
// at any edge where start is high and busy is low. busy stays low, so a
// new box may enter in every cycle.
// Output: done is high for one cycle with containment (0 inside,
// 1 intersecting, 2 outside). The receiver cannot hold results off; each
// result leaves on the cycle it is shown and results keep input order.
// One stage sorts each axis into low and high coordinates, then every
// plane cell spends one stage on its six products and one on the two
// sums and the verdict. Throughput is one box per cycle.
// Configuration: cfg_ready is always high; index 0 holds plane_count,
// indexes 1 to 6 hold the packed planes. Write only while no box is in
// flight.
// Reset clears plane_count and all planes and drops every box in flight.
module aabb_frustum_classify_unit #(
    parameter int MAX_PLANES  = afc_pkg::DEF_MAX_PLANES,
    parameter int COORD_WIDTH = afc_pkg::DEF_COORD_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [COORD_WIDTH-1:0]            box_min_x,
    input  logic [COORD_WIDTH-1:0]            box_min_y,
    input  logic [COORD_WIDTH-1:0]            box_min_z,
    input  logic [COORD_WIDTH-1:0]            box_max_x,
    input  logic [COORD_WIDTH-1:0]            box_max_y,
    input  logic [COORD_WIDTH-1:0]            box_max_z,
    output logic                              done,
    output logic [1:0]                        containment,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [afc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [afc_pkg::PLANE_W-1:0]       cfg_data
);
    import afc_pkg::*;

    localparam int LATENCY = 1 + 2 * MAX_PLANES;
    localparam int CNT_W   = $clog2(MAX_PLANES + 1) + COUNT_W;

    logic [COUNT_W-1:0]      count_reg;
    logic [PLANE_W-1:0]      plane [MAX_PLANES];
    logic [MAX_PLANES-1:0]   enable;
    logic                    accept;

    afc_ctl_t                         in_ctl_reg, in_ctl_next;
    logic [AXES-1:0][COORD_WIDTH-1:0] in_lo_reg, in_hi_reg;
    logic [AXES-1:0][COORD_WIDTH-1:0] in_lo_next, in_hi_next;
    logic [AXES-1:0][COORD_WIDTH-1:0] box_lo, box_hi;

    afc_ctl_t                         ctl_chain [MAX_PLANES+1];
    logic [AXES-1:0][COORD_WIDTH-1:0] lo_chain  [MAX_PLANES+1];
    logic [AXES-1:0][COORD_WIDTH-1:0] hi_chain  [MAX_PLANES+1];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cfg_valid && cfg_ready && (cfg_index == REG_PLANE_COUNT))
            count_reg <= cfg_data[COUNT_W-1:0];
    end

    for (genvar k = 0; k < MAX_PLANES; k++)
    begin : g_plane
        if (k < PLANE_REGS)
        begin : g_reg
            logic [PLANE_W-1:0] plane_reg;
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    plane_reg <= '0;
                else if (cfg_valid && cfg_ready
                         && (cfg_index == REG_PLANE_ZERO + CFG_IDX_W'(k)))
                    plane_reg <= cfg_data;
            end
            assign plane[k] = plane_reg;
        end
        else
        begin : g_zero
            // no register reaches this slot: an all-zero plane
            assign plane[k] = '0;
        end
        // a count above MAX_PLANES enables every cell
        assign enable[k] = CNT_W'(count_reg) > CNT_W'(k);
    end

    // input stage: order each axis into low and high coordinates
    assign box_lo = {box_min_z, box_min_y, box_min_x};
    assign box_hi = {box_max_z, box_max_y, box_max_x};

    always_comb
    begin
        in_ctl_next.valid = accept;
        in_ctl_next.res   = CONT_INSIDE;
        for (int j = 0; j < AXES; j++)
        begin
            if ($signed(box_lo[j]) > $signed(box_hi[j]))
            begin
                in_lo_next[j] = box_hi[j];
                in_hi_next[j] = box_lo[j];
            end
            else
            begin
                in_lo_next[j] = box_lo[j];
                in_hi_next[j] = box_hi[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_ctl_reg <= '0;
        else
            in_ctl_reg <= in_ctl_next;
    end

    always_ff @(posedge clk)
    begin
        in_lo_reg <= in_lo_next;
        in_hi_reg <= in_hi_next;
    end

    assign ctl_chain[0] = in_ctl_reg;
    assign lo_chain[0]  = in_lo_reg;
    assign hi_chain[0]  = in_hi_reg;

    for (genvar k = 0; k < MAX_PLANES; k++)
    begin : g_cell
        afc_cell #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .plane   (plane[k]),
            .enable  (enable[k]),
            .ctl_in  (ctl_chain[k]),
            .lo_in   (lo_chain[k]),
            .hi_in   (hi_chain[k]),
            .ctl_out (ctl_chain[k+1]),
            .lo_out  (lo_chain[k+1]),
            .hi_out  (hi_chain[k+1])
        );
    end

    assign done        = ctl_chain[MAX_PLANES].valid;
    assign containment = ctl_chain[MAX_PLANES].res;

    // every accepted transaction yields exactly one result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("accepted box produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |-> ##LATENCY !done)
        else $error("result without an accepted box");

    a_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (containment == CONT_INSIDE || containment == CONT_INTERSECT
                  || containment == CONT_OUTSIDE))
        else $error("illegal containment code");

endmodule

FILE: sim/tb_aabb_frustum_classify_unit.sv
`timescale 1ns / 100ps

module tb_aabb_frustum_classify_unit;
    import afc_pkg::*;

    localparam int MAX_PL          = DEF_MAX_PLANES;
    localparam int CW              = DEF_COORD_WIDTH;
    localparam int PIPE_DEPTH      = 1 + 2 * MAX_PL;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int RANDOM_PHASES   = 12;
    localparam int BOXES_PER_PHASE = 71;
    localparam int Q_ONE           = 1 << D_SHIFT;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(REG_PLANE_ZERO + PLANE_REGS);

    typedef struct packed {
        logic [CW-1:0] min_x;
        logic [CW-1:0] min_y;
        logic [CW-1:0] min_z;
        logic [CW-1:0] max_x;
        logic [CW-1:0] max_y;
        logic [CW-1:0] max_z;
    } box_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [CW-1:0]        box_min_x = '0;
    logic [CW-1:0]        box_min_y = '0;
    logic [CW-1:0]        box_min_z = '0;
    logic [CW-1:0]        box_max_x = '0;
    logic [CW-1:0]        box_max_y = '0;
    logic [CW-1:0]        box_max_z = '0;
    logic                 done;
    logic [1:0]           containment;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PLANE_W-1:0]   cfg_data = '0;

    // register mirror used by the containment predictor
    logic [COUNT_W-1:0]   plane_count_mirror = '0;
    logic [PLANE_W-1:0]   plane_mirror [PLANE_REGS] = '{default: '0};
    logic [PLANE_W-1:0]   plane_stage [PLANE_REGS] = '{default: '0};

    logic [1:0]           expected_containment [$];
    logic [1:0]           want;
    int                   fail_count = 0;
    int unsigned          cycle_count = 0;

    aabb_frustum_classify_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .box_min_x   (box_min_x),
        .box_min_y   (box_min_y),
        .box_min_z   (box_min_z),
        .box_max_x   (box_max_x),
        .box_max_y   (box_max_y),
        .box_max_z   (box_max_z),
        .done        (done),
        .containment (containment),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [1:0] classify_box(input box_t b);
        longint lo [AXES];
        longint hi [AXES];
        longint ca, cb, cc, cd, px, py, pz, s;
        int n, i, k;
        logic front, behind;
        logic [1:0] verdict;
        logic [PLANE_W-1:0] pl;
        lo[0] = $signed(b.min_x);
        lo[1] = $signed(b.min_y);
        lo[2] = $signed(b.min_z);
        hi[0] = $signed(b.max_x);
        hi[1] = $signed(b.max_y);
        hi[2] = $signed(b.max_z);
        n = (plane_count_mirror > MAX_PL) ? MAX_PL : plane_count_mirror;
        verdict = CONT_INSIDE;
        for (i = 0; i < n; i++)
        begin
            // stop at the first plane that does not report inside
            if (verdict == CONT_INSIDE)
            begin
                pl = plane_mirror[i];
                ca = $signed(pl[COEF_W-1:0]);
                cb = $signed(pl[2*COEF_W-1:COEF_W]);
                cc = $signed(pl[3*COEF_W-1:2*COEF_W]);
                cd = $signed(pl[PLANE_W-1:D_LSB]);
                cd = cd << D_SHIFT;
                front = 1'b0;
                behind = 1'b0;
                for (k = 0; k < 8; k++)
                begin
                    px = k[0] ? hi[0] : lo[0];
                    py = k[1] ? hi[1] : lo[1];
                    pz = k[2] ? hi[2] : lo[2];
                    s = ca * px + cb * py + cc * pz + cd;
                    if (s > 0)
                        front = 1'b1;
                    else if (s < 0)
                        behind = 1'b1;
                end
                if (!front)
                    verdict = CONT_OUTSIDE;
                else if (behind)
                    verdict = CONT_INTERSECT;
            end
        end
        return verdict;
    endfunction

    function automatic box_t make_box(input int x0, y0, z0, x1, y1, z1);
        box_t b;
        b.min_x = x0[CW-1:0];
        b.min_y = y0[CW-1:0];
        b.min_z = z0[CW-1:0];
        b.max_x = x1[CW-1:0];
        b.max_y = y1[CW-1:0];
        b.max_z = z1[CW-1:0];
        return b;
    endfunction

    function automatic logic [PLANE_W-1:0] pack_plane(input int a, b, c, d);
        return {d[COEF_W-1:0], c[COEF_W-1:0], b[COEF_W-1:0], a[COEF_W-1:0]};
    endfunction

    function automatic logic [PLANE_W-1:0] random_plane();
        logic [PLANE_W-1:0] p;
        logic [COEF_W-1:0] extremes [4];
        int kind, j;
        extremes = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
        kind = $urandom_range(99);
        p = {$urandom, $urandom};
        if (kind < 10)
        begin
            for (j = 0; j < 4; j++)
                p[j*COEF_W +: COEF_W] = extremes[$urandom_range(3)];
        end
        else if (kind >= 25)
        begin
            // frustum-like: unit-range normal, offset mostly keeping the origin in front
            for (j = 0; j < AXES; j++)
                p[j*COEF_W +: COEF_W] = COEF_W'(int'($urandom_range(2 * Q_ONE)) - Q_ONE);
            p[D_LSB +: COEF_W] = COEF_W'(int'($urandom_range(36000)) - 4000);
        end
        return p;
    endfunction

    function automatic box_t random_box();
        box_t b;
        int lo [AXES];
        int hi [AXES];
        int kind, j, mid, half;
        kind = $urandom_range(99);
        if (kind < 15)
            b = {$urandom, $urandom, $urandom};
        else
        begin
            for (j = 0; j < AXES; j++)
            begin
                mid = int'($urandom_range(8000)) - 4000;
                half = (kind < 60) ? $urandom_range(300) : $urandom_range(3000);
                lo[j] = mid - half;
                hi[j] = mid + half;
            end
            if (kind < 25)
            begin
                // swap one axis so min lies above max
                j = $urandom_range(AXES - 1);
                mid = lo[j];
                lo[j] = hi[j];
                hi[j] = mid;
            end
            b = make_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
        end
        return b;
    endfunction

    task automatic send_box(input box_t b);
        start <= 1'b1;
        box_min_x <= b.min_x;
        box_min_y <= b.min_y;
        box_min_z <= b.min_z;
        box_max_x <= b.max_x;
        box_max_y <= b.max_y;
        box_max_z <= b.max_z;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        expected_containment = {expected_containment, classify_box(b)};
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PLANE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        if (idx == REG_PLANE_COUNT)
            plane_count_mirror = data[COUNT_W-1:0];
        else if (idx < REG_SPARE)
            plane_mirror[idx - REG_PLANE_ZERO] = data;
    endtask

    task automatic apply_config(input logic [COUNT_W-1:0] count);
        int i;
        write_reg(REG_PLANE_COUNT, PLANE_W'(count));
        for (i = 0; i < PLANE_REGS; i++)
            write_reg(CFG_IDX_W'(REG_PLANE_ZERO + i), plane_stage[i]);
        cfg_valid <= 1'b0;
    endtask

    // hold off until every box in flight has reported
    task automatic wait_idle();
        start <= 1'b0;
        while (expected_containment.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_reset_state();
        send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
        send_box(make_box(32767, 0, -1, -32768, 5, -2));
        wait_idle();
        // planes still clear: every corner lies on the plane
        write_reg(REG_PLANE_COUNT, PLANE_W'(MAX_PL));
        cfg_valid <= 1'b0;
        send_box(make_box(1, 2, 3, 4, 5, 6));
        wait_idle();
    endtask

    task automatic test_single_plane();
        int i;
        for (i = 0; i < PLANE_REGS; i++)
            plane_stage[i] = '0;
        plane_stage[0] = pack_plane(Q_ONE, 0, 0, 0);
        apply_config(COUNT_W'(1));
        send_box(make_box(1, -9, -9, 10, 9, 9));
        send_box(make_box(-5, -9, -9, 5, 9, 9));
        send_box(make_box(-10, -9, -9, -1, 9, 9));
        send_box(make_box(0, -9, -9, 7, 9, 9));
        send_box(make_box(0, -9, -9, 0, 9, 9));
        send_box(make_box(-3, -9, -9, 0, 9, 9));
        send_box(make_box(5, -9, -9, -5, 9, 9));
        wait_idle();
    endtask

    task automatic test_plane_order();
        plane_stage[0] = pack_plane(Q_ONE, 0, 0, 100);
        plane_stage[1] = pack_plane(0, Q_ONE, 0, 0);
        plane_stage[2] = pack_plane(0, 0, Q_ONE, -1000);
        apply_config(COUNT_W'(3));
        send_box(make_box(0, -5, 0, 10, 5, 10));
        send_box(make_box(0, 1, 0, 10, 5, 10));
        send_box(make_box(0, 1, 1000, 10, 5, 1200));
        wait_idle();
        write_reg(REG_PLANE_COUNT, PLANE_W'(1));
        cfg_valid <= 1'b0;
        send_box(make_box(0, -5, 0, 10, 5, 10));
        wait_idle();
    endtask

    task automatic test_extremes_and_count();
        int i;
        plane_stage[0] = pack_plane(-32768, -32768, -32768, -32768);
        for (i = 1; i < PLANE_REGS; i++)
            plane_stage[i] = pack_plane(32767, 32767, 32767, 32767);
        // count above the plane limit
        apply_config(COUNT_W'(7));
        send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
        send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
        send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
        wait_idle();
        // spare index must leave every register alone
        write_reg(REG_SPARE, '1);
        cfg_valid <= 1'b0;
        send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int phase, i, n, idle_pct;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            for (i = 0; i < PLANE_REGS; i++)
                plane_stage[i] = random_plane();
            apply_config(COUNT_W'(phase % 8));
            idle_pct = (phase % 3 == 1) ? 53 : (phase % 3 == 2) ? 28 : 0;
            for (n = 0; n < BOXES_PER_PHASE; n++)
            begin
                // leave each cycle idle with the phase's probability
                while (idle_pct != 0 && $urandom_range(99) < idle_pct)
                begin
                    start <= 1'b0;
                    @(posedge clk);
                end
                send_box(random_box());
            end
            wait_idle();
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done !== 1'b0)
        begin
            if (expected_containment.size() == 0)
            begin
                $error("containment: result with nothing expected, actual %0d", containment);
                fail_count++;
            end
            else
            begin
                want = expected_containment.pop_front();
                if (containment !== want)
                begin
                    $error("containment: expected %0d, actual %0d", want, containment);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_single_plane();
        test_plane_order();
        test_extremes_and_count();
        test_random_traffic();
        // catch any stray transaction after the last expected one
        repeat (3 * PIPE_DEPTH) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
